// ----- hw/rtl/mse_pkg.sv -----
// Shared types, symbol codes and the character-to-code table of the Morse symbol encoder.
package mse_pkg;

	localparam int unsigned CharW   = 8;
	localparam int unsigned SymW    = 2;
	localparam int unsigned MaxLen  = 6;
	localparam int unsigned LenW    = 3;
	localparam int unsigned MaskW   = MaxLen;

	localparam logic [SymW-1:0] SYM_DOT   = 2'd0;
	localparam logic [SymW-1:0] SYM_DASH  = 2'd1;
	localparam logic [SymW-1:0] SYM_SLASH = 2'd2;
	localparam logic [SymW-1:0] SYM_SEP   = 2'd3;

	localparam logic [CharW-1:0] UPPER_LO = 8'd64;
	localparam logic [CharW-1:0] UPPER_HI = 8'd91;
	localparam logic [CharW-1:0] CASE_OFS = 8'd32;

	typedef struct packed {
		logic                   known;
		logic [LenW-1:0]        len;
		logic [MaxLen*SymW-1:0] syms;
	} code_t;

	function automatic logic [CharW-1:0] fold_case(input logic [CharW-1:0] ch);
		logic [CharW-1:0] res;
		res = ch;
		if (ch > UPPER_LO && ch < UPPER_HI) begin
			res = ch + CASE_OFS;
		end
		return res;
	endfunction

	// The dash mask is left aligned: its top bit is the first symbol, a set bit is a dash.
	function automatic code_t code_lookup(input logic [CharW-1:0] ch);
		code_t           res;
		logic [LenW-1:0] len;
		logic [MaskW-1:0] mask;
		logic            known;
		logic            slashes;
		known   = 1'b1;
		slashes = 1'b0;
		len     = '0;
		mask    = '0;
		unique case (ch)
			8'h61: begin len = 3'd2; mask = 6'b010000; end
			8'h62: begin len = 3'd4; mask = 6'b100000; end
			8'h63: begin len = 3'd4; mask = 6'b101000; end
			8'h64: begin len = 3'd3; mask = 6'b100000; end
			8'h65: begin len = 3'd1; mask = 6'b000000; end
			8'h66: begin len = 3'd4; mask = 6'b001000; end
			8'h67: begin len = 3'd3; mask = 6'b110000; end
			8'h68: begin len = 3'd4; mask = 6'b000000; end
			8'h69: begin len = 3'd2; mask = 6'b000000; end
			8'h6a: begin len = 3'd4; mask = 6'b011100; end
			8'h6b: begin len = 3'd3; mask = 6'b101000; end
			8'h6c: begin len = 3'd4; mask = 6'b010000; end
			8'h6d: begin len = 3'd2; mask = 6'b110000; end
			8'h6e: begin len = 3'd2; mask = 6'b100000; end
			8'h6f: begin len = 3'd3; mask = 6'b111000; end
			8'h70: begin len = 3'd4; mask = 6'b011000; end
			8'h71: begin len = 3'd4; mask = 6'b110100; end
			8'h72: begin len = 3'd3; mask = 6'b010000; end
			8'h73: begin len = 3'd3; mask = 6'b000000; end
			8'h74: begin len = 3'd1; mask = 6'b100000; end
			8'h75: begin len = 3'd3; mask = 6'b001000; end
			8'h76: begin len = 3'd4; mask = 6'b000100; end
			8'h77: begin len = 3'd3; mask = 6'b011000; end
			8'h78: begin len = 3'd4; mask = 6'b100100; end
			8'h79: begin len = 3'd4; mask = 6'b101100; end
			8'h7a: begin len = 3'd4; mask = 6'b110000; end
			8'h30: begin len = 3'd5; mask = 6'b111110; end
			8'h31: begin len = 3'd5; mask = 6'b011110; end
			8'h32: begin len = 3'd5; mask = 6'b001110; end
			8'h33: begin len = 3'd5; mask = 6'b000110; end
			8'h34: begin len = 3'd5; mask = 6'b000010; end
			8'h35: begin len = 3'd5; mask = 6'b000000; end
			8'h36: begin len = 3'd5; mask = 6'b100000; end
			8'h37: begin len = 3'd5; mask = 6'b110000; end
			8'h38: begin len = 3'd5; mask = 6'b111000; end
			8'h39: begin len = 3'd5; mask = 6'b111100; end
			8'h20: begin len = 3'd3; slashes = 1'b1; end
			8'h2e: begin len = 3'd6; mask = 6'b010101; end
			8'h2c: begin len = 3'd6; mask = 6'b110011; end
			8'h3a: begin len = 3'd6; mask = 6'b111000; end
			8'h3f: begin len = 3'd6; mask = 6'b001100; end
			8'h2d: begin len = 3'd6; mask = 6'b100001; end
			8'h2f: begin len = 3'd5; mask = 6'b100100; end
			8'h40: begin len = 3'd6; mask = 6'b011010; end
			8'h3d: begin len = 3'd5; mask = 6'b100010; end
			default: begin known = 1'b0; end
		endcase
		res.known = known;
		res.len   = len;
		for (int i = 0; i < MaxLen; i++) begin
			if (slashes) begin
				res.syms[i*SymW +: SymW] = SYM_SLASH;
			end else if (mask[MaskW-1-i]) begin
				res.syms[i*SymW +: SymW] = SYM_DASH;
			end else begin
				res.syms[i*SymW +: SymW] = SYM_DOT;
			end
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/mse_if.sv -----
// Valid/ready channel interfaces for characters in and symbols out.
interface mse_char_if;
	logic                       valid;
	logic                       ready;
	logic [mse_pkg::CharW-1:0]  char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface mse_sym_if;
	logic                      valid;
	logic                      ready;
	logic [mse_pkg::SymW-1:0]  symbol;
	logic                      last_symbol;

	modport source (output valid, output symbol, output last_symbol, input ready);
	modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

// ----- hw/rtl/mse_code_rom.sv -----
// Code table stage: folds the case of each request and registers its code.
module mse_code_rom (
	input  logic                clk,
	input  logic                arst_n,
	mse_char_if.sink            chars,
	output mse_pkg::code_t      code,
	output logic                code_valid,
	input  logic                code_ready
);

	logic            valid_s1;
	mse_pkg::code_t  rd_s1;
	logic            advance;

	assign advance     = !valid_s1 || !rd_s1.known || code_ready;
	assign chars.ready = advance;
	assign code_valid  = valid_s1 && rd_s1.known;
	assign code        = rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_s1 <= mse_pkg::code_lookup(mse_pkg::fold_case(chars.char_code));
		end
	end

endmodule

// ----- hw/rtl/mse_serializer.sv -----
// Symbol serializer: sends one code symbol per cycle while the output is ready, then the closing separator.
module mse_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  mse_pkg::code_t      code,
	input  logic                code_valid,
	output logic                code_ready,
	mse_sym_if.source           syms
);

	logic                                     busy_q;
	logic [mse_pkg::LenW-1:0]                 remain_q;
	logic [mse_pkg::MaxLen*mse_pkg::SymW-1:0] sym_q;
	logic                                     fire;
	logic                                     at_sep;

	assign at_sep           = (remain_q == '0);
	assign fire             = busy_q && syms.ready;
	assign code_ready       = !busy_q || (fire && at_sep);
	assign syms.valid       = busy_q;
	assign syms.symbol      = at_sep ? mse_pkg::SYM_SEP : sym_q[mse_pkg::SymW-1:0];
	assign syms.last_symbol = at_sep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			remain_q <= '0;
		end else if (code_valid && code_ready) begin
			busy_q   <= 1'b1;
			remain_q <= code.len;
		end else if (fire) begin
			if (at_sep) begin
				busy_q <= 1'b0;
			end else begin
				remain_q <= remain_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (code_valid && code_ready) begin
			sym_q <= code.syms;
		end else if (fire && !at_sep) begin
			sym_q <= sym_q >> mse_pkg::SymW;
		end
	end

endmodule

// ----- hw/rtl/morse_symbol_encoder.sv -----
// Top level of the Morse symbol encoder: code table stage followed by the symbol serializer.
//
//   channel   direction  payload
//   chars     in         char_code[7:0]
//   syms      out        symbol[1:0], last_symbol
//
// A known character gives its code length plus one symbols, one per cycle while
// the output is ready, so it sends two to seven symbols; unknown characters are
// dropped in the table stage. The table read is registered. A new request is
// taken while the serializer is still sending the previous code. arst_n clears
// all valid and count state. A stalled output holds its symbol and backs up the
// table stage and then the input.
module morse_symbol_encoder (
	input  logic      clk,
	input  logic      arst_n,
	mse_char_if.sink  chars,
	mse_sym_if.source syms
);

	mse_pkg::code_t code;
	logic           code_valid;
	logic           code_ready;

	mse_code_rom u_rom (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.code       (code),
		.code_valid (code_valid),
		.code_ready (code_ready)
	);

	mse_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.code       (code),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.syms       (syms)
	);

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the Morse symbol encoder: character requests in, checked symbols out.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [mse_pkg::SymW-1:0] symbol;
		logic                     last_symbol;
	} morse_sym_t;

	localparam logic [mse_pkg::CharW-1:0] FOLD_ABOVE = 8'd64;
	localparam logic [mse_pkg::CharW-1:0] FOLD_BELOW = 8'd91;
	localparam logic [mse_pkg::CharW-1:0] FOLD_OFS   = 8'd32;
	localparam int                        MaxReports = 10;
	localparam int                        HoldCycles = 300;

	class morse_scoreboard;
		morse_sym_t expected_syms[$];
		int         mismatches;
		int         chars_noted;
		int         unknown_chars;
		int         syms_checked;

		function string dot_dash_of(input logic [mse_pkg::CharW-1:0] c);
			case (c)
				"a": return ".-";     "b": return "-...";   "c": return "-.-.";
				"d": return "-..";    "e": return ".";      "f": return "..-.";
				"g": return "--.";    "h": return "....";   "i": return "..";
				"j": return ".---";   "k": return "-.-";    "l": return ".-..";
				"m": return "--";     "n": return "-.";     "o": return "---";
				"p": return ".--.";   "q": return "--.-";   "r": return ".-.";
				"s": return "...";    "t": return "-";      "u": return "..-";
				"v": return "...-";   "w": return ".--";    "x": return "-..-";
				"y": return "-.--";   "z": return "--..";
				"0": return "-----";  "1": return ".----";  "2": return "..---";
				"3": return "...--";  "4": return "....-";  "5": return ".....";
				"6": return "-....";  "7": return "--...";  "8": return "---..";
				"9": return "----.";
				" ": return "///";
				".": return ".-.-.-"; ",": return "--..--"; ":": return "---...";
				"?": return "..--.."; "-": return "-....-"; "/": return "-..-.";
				"@": return ".--.-."; "=": return "-...-";
				default: return "";
			endcase
		endfunction

		function void report(input string msg);
			mismatches++;
			if (mismatches <= MaxReports) begin
				$display("%0t: %s", $realtime, msg);
			end
		endfunction

		function void note_char(input logic [mse_pkg::CharW-1:0] ch);
			logic [mse_pkg::CharW-1:0] c;
			string                     code;
			morse_sym_t                item;
			c = ch;
			chars_noted++;
			if (c > FOLD_ABOVE && c < FOLD_BELOW) begin
				c = c + FOLD_OFS;
			end
			code = dot_dash_of(c);
			if (code.len() == 0) begin
				unknown_chars++;
				return;
			end
			for (int i = 0; i < code.len() && i < mse_pkg::MaxLen; i++) begin
				case (code[i])
					"-": item.symbol = mse_pkg::SYM_DASH;
					"/": item.symbol = mse_pkg::SYM_SLASH;
					default: item.symbol = mse_pkg::SYM_DOT;
				endcase
				item.last_symbol = 1'b0;
				expected_syms.push_back(item);
			end
			item.symbol      = mse_pkg::SYM_SEP;
			item.last_symbol = 1'b1;
			expected_syms.push_back(item);
		endfunction

		function void check_symbol(input logic [mse_pkg::SymW-1:0] sym, input logic last);
			morse_sym_t want;
			syms_checked++;
			if (expected_syms.size() == 0) begin
				report($sformatf("unexpected symbol %0d last %0d", sym, last));
				return;
			end
			want = expected_syms.pop_front();
			if (sym !== want.symbol || last !== want.last_symbol) begin
				report($sformatf("symbol mismatch: expected %0d last %0d, got %0d last %0d",
					want.symbol, want.last_symbol, sym, last));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic hold_req;
	logic no_idle;

	mse_char_if chars_if ();
	mse_sym_if  syms_if ();

	morse_scoreboard sb;

	morse_symbol_encoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if.sink),
		.syms   (syms_if.source)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = ~clk;
	end

	initial begin
		sb = new();
	end

	always @(posedge clk) begin
		if (arst_n && chars_if.valid && chars_if.ready) begin
			sb.note_char(chars_if.char_code);
		end
		if (arst_n && syms_if.valid && syms_if.ready) begin
			sb.check_symbol(syms_if.symbol, syms_if.last_symbol);
		end
	end

	task automatic send_char(input logic [mse_pkg::CharW-1:0] ch);
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= ch;
		do @(posedge clk); while (!chars_if.ready);
	endtask

	task automatic sender_gap(input int cycles);
		chars_if.valid     <= 1'b0;
		chars_if.char_code <= mse_pkg::CharW'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic maybe_gap();
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			sender_gap($urandom_range(1, 16));
		end
	endtask

	function automatic logic [mse_pkg::CharW-1:0] random_char();
		string known_chars;
		known_chars = "abcdefghijklmnopqrstuvwxyz0123456789 .,:?-/@=ABCDEFGHIJKLMNOPQRSTUVWXYZ";
		if ($urandom_range(0, 4) == 0) begin
			return mse_pkg::CharW'($urandom_range(0, 255));
		end
		return known_chars[$urandom_range(0, known_chars.len() - 1)];
	endfunction

	// The receiver runs in bursts of ready and stall, with one long hold-off on request.
	initial begin
		syms_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				syms_if.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end else if (no_idle) begin
				syms_if.ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 2) != 0) begin
				syms_if.ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				syms_if.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	initial begin
		logic [mse_pkg::CharW-1:0] directed_chars[$];
		directed_chars = '{"A", "Z", "a", "z", "0", "9", " ", ".", ",", ":", "?", "-",
			"/", "@", "=", 8'h5B, 8'h60, 8'h7B, 8'h00, 8'h0A, 8'h7F, 8'h80, 8'hFF, "k"};
		hold_req = 1'b0;
		no_idle  = 1'b0;
		arst_n             <= 1'b0;
		chars_if.valid     <= 1'b0;
		chars_if.char_code <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed_chars[i]) begin
			send_char(directed_chars[i]);
			maybe_gap();
		end

		for (int i = 0; i < 230; i++) begin
			send_char(random_char());
			maybe_gap();
		end

		hold_req = 1'b1;
		for (int i = 0; i < 30; i++) begin
			send_char(random_char());
		end

		no_idle = 1'b1;
		for (int i = 0; i < 60; i++) begin
			send_char(random_char());
		end
		chars_if.valid <= 1'b0;

		while (sb.expected_syms.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("Sent %0d characters (%0d outside the table) and checked %0d symbols.",
			sb.chars_noted, sb.unknown_chars, sb.syms_checked);
		$display("The receiver stalled in random bursts and once for %0d cycles.", HoldCycles);
		if (sb.mismatches == 0 && sb.expected_syms.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d symbols never arrived.",
				sb.mismatches, sb.expected_syms.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout: the run did not complete.");
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/mse_pkg.sv
hw/rtl/mse_if.sv
hw/rtl/mse_code_rom.sv
hw/rtl/mse_serializer.sv
hw/rtl/morse_symbol_encoder.sv
test/testbench.sv
